[design/rel_pkg.sv]
// Shared types and constants of the rotary encoder lockout counter.
package rel_pkg;

    localparam int LOCKOUT_W   = 20;
    localparam int ELAPSED_W   = 21;
    localparam int COUNT_W     = 8;
    localparam int MODE_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int DIV_W       = 9;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    localparam int MODE_COUNT_DEF = 9;

    localparam logic [LOCKOUT_W-1:0] ROTARY_LOCKOUT_RST = 20'd15000;
    localparam logic [LOCKOUT_W-1:0] BUTTON_LOCKOUT_RST = 20'd150000;
    localparam logic [COUNT_W-1:0]   COUNT_MODULUS_RST  = 8'd40;
    localparam logic [MODE_W-1:0]    MODE_RST           = 4'd6;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX        = '1;

    // request kinds
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_A_FALL = 2'd1;
    localparam logic [1:0] REQ_B_FALL = 2'd2;
    localparam logic [1:0] REQ_BUTTON = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROTARY_LOCKOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_LOCKOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODULUS  = 2'd2;

    typedef struct packed {
        logic [LOCKOUT_W-1:0] rotary_lockout;
        logic [LOCKOUT_W-1:0] button_lockout;
        logic [COUNT_W-1:0]   count_modulus;
    } rel_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } rel_state_t;

endpackage

[design/rel_cfg.sv]
// Configuration register file of the rotary encoder lockout counter.
module rel_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rel_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rel_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rel_pkg::rel_cfg_t                cfg_out
);
    import rel_pkg::*;

    rel_cfg_t cfg_reg;
    rel_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ROTARY_LOCKOUT: cfg_next.rotary_lockout = cfg_data[LOCKOUT_W-1:0];
                REG_BUTTON_LOCKOUT: cfg_next.button_lockout = cfg_data[LOCKOUT_W-1:0];
                REG_COUNT_MODULUS:  cfg_next.count_modulus  = cfg_data[COUNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rotary_lockout <= ROTARY_LOCKOUT_RST;
            cfg_reg.button_lockout <= BUTTON_LOCKOUT_RST;
            cfg_reg.count_modulus  <= COUNT_MODULUS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/rel_divu.sv]
// Shared restoring remainder unit, one dividend bit per cycle.
module rel_divu (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [rel_pkg::DIV_W-1:0]      dividend,
    input  logic [rel_pkg::COUNT_W-1:0]    divisor,
    output logic                           done,
    output logic [rel_pkg::COUNT_W-1:0]    remainder
);
    import rel_pkg::*;

    logic [DIV_W-1:0]     dvd_reg,  dvd_next;
    logic [COUNT_W-1:0]   dsr_reg,  dsr_next;
    logic [COUNT_W-1:0]   rem_reg,  rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 done_reg, done_next;
    logic [COUNT_W:0]     trial;

    assign trial     = {rem_reg, dvd_reg[DIV_W-1]};
    assign done      = done_reg;
    assign remainder = rem_reg;

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next = dividend;
            dsr_next = divisor;
            rem_next = '0;
            cnt_next = DIV_CNT_W'(DIV_W);
        end else if (cnt_reg != '0) begin
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            // remainder stays below the divisor, so it fits back in COUNT_W bits
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = COUNT_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[COUNT_W-1:0];
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

endmodule

[design/rotary_encoder_lockout_counter.sv]
// Rotary encoder and push-button lockout counter. Each request is a tick, an
// A or B falling edge, or a button press, and yields one result holding the
// position, mode, toggle bit and an accepted-edge flag. A tick or a rejected
// edge goes from the input straight to the FIN state, where its result is
// loaded once the output register is free; an accepted edge first passes
// through the DIV state, run by the shared 9-step remainder unit that wraps the
// position count and the mode. The next request is taken once the result is
// loaded into the output register, even while that result still waits
// downstream. Configuration writes are taken in every cycle.
module rotary_encoder_lockout_counter #(
    parameter int MODE_COUNT = rel_pkg::MODE_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] line_a_level, [1] line_b_level,
                                                      // [2] button_level, [7:3] zero
    input  logic [1:0]                     s_tuser,   // [1:0] req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [7:0] position, [11:8] mode_value,
                                                      // [12] toggle_bit, [15:13] zero
    output logic                           m_tuser,   // [0] changed
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rel_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rel_pkg::*;

    rel_cfg_t   cfg;
    rel_state_t state_reg, state_next;

    logic [1:0]           kind_reg;
    logic                 hit_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic                 status_reg;
    logic [ELAPSED_W-1:0] rot_el_reg;
    logic [ELAPSED_W-1:0] btn_el_reg;
    logic                 m_tvalid_reg;
    logic [15:0]          m_tdata_reg;
    logic                 m_tuser_reg;

    logic                 in_acc;
    logic                 out_free;
    logic                 out_load;
    logic                 div_start;
    logic                 div_done;
    logic [COUNT_W-1:0]   div_rem;
    logic [COUNT_W-1:0]   eff_mod;
    logic                 rot_ok;
    logic                 btn_ok;
    logic                 hit;
    logic [DIV_W-1:0]     div_dvd;
    logic [COUNT_W-1:0]   div_dsr;
    logic [COUNT_W-1:0]   count_new;
    logic [MODE_W-1:0]    mode_new;
    logic                 status_new;
    logic [ELAPSED_W-1:0] rot_el_new;
    logic [ELAPSED_W-1:0] btn_el_new;

    rel_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    rel_divu u_divu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign eff_mod = (cfg.count_modulus == '0) ? COUNT_W'(1) : cfg.count_modulus;
    assign rot_ok  = rot_el_reg > {1'b0, cfg.rotary_lockout};
    assign btn_ok  = btn_el_reg > {1'b0, cfg.button_lockout};
    assign in_acc  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        case (s_tuser)
            REQ_A_FALL: hit = rot_ok && s_tdata[1] && !s_tdata[0];
            REQ_B_FALL: hit = rot_ok && s_tdata[0] && !s_tdata[1];
            REQ_BUTTON: hit = btn_ok && s_tdata[2];
            default:    hit = 1'b0;
        endcase
    end

    // operands for the wrap of the accepted edge
    always_comb begin
        case (s_tuser)
            REQ_A_FALL: begin
                div_dvd = {1'b0, count_reg} + DIV_W'(1);
                div_dsr = eff_mod;
            end
            REQ_B_FALL: begin
                div_dvd = {1'b0, count_reg} + {1'b0, eff_mod} - DIV_W'(1);
                div_dsr = eff_mod;
            end
            default: begin
                div_dvd = DIV_W'(mode_reg) + DIV_W'(1);
                div_dsr = COUNT_W'(MODE_COUNT);
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = hit ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                div_start = s_tvalid && hit;
            end
            ST_FIN:  out_load = out_free;
            default: ;
        endcase
    end

    // state update for the finished request
    always_comb begin
        count_new  = count_reg;
        mode_new   = mode_reg;
        status_new = status_reg;
        rot_el_new = rot_el_reg;
        btn_el_new = btn_el_reg;
        if (kind_reg == REQ_TICK) begin
            if (rot_el_reg != ELAPSED_MAX) rot_el_new = rot_el_reg + 1'b1;
            if (btn_el_reg != ELAPSED_MAX) btn_el_new = btn_el_reg + 1'b1;
        end else if (hit_reg) begin
            if (kind_reg == REQ_BUTTON) begin
                mode_new   = div_rem[MODE_W-1:0];
                status_new = !status_reg;
                btn_el_new = '0;
            end else begin
                count_new  = div_rem;
                rot_el_new = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            mode_reg     <= MODE_RST;
            status_reg   <= 1'b0;
            rot_el_reg   <= '0;
            btn_el_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                count_reg    <= count_new;
                mode_reg     <= mode_new;
                status_reg   <= status_new;
                rot_el_reg   <= rot_el_new;
                btn_el_reg   <= btn_el_new;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            kind_reg <= s_tuser;
            hit_reg  <= hit;
        end
        if (out_load) begin
            m_tdata_reg <= {3'b000, status_new, mode_new, count_new};
            m_tuser_reg <= hit_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[design/rel_checker.sv]
// Port-level checks of the rotary encoder lockout counter, bound to the top level.
module rel_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a pending result is not withdrawn
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one in flight");

    // a result appears only after a request has been taken
    a_out_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without request");

    // pad bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:13] == 3'b000)
        else $error("result pad bits set");

endmodule

bind rotary_encoder_lockout_counter rel_checker u_rel_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
